[sv/kvt_pkg.sv]
// ----------------------------------------------------------------------------
// Key/value table package
// Request and response payload types and request type codes shared by the
// key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // Request type codes.
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_GET = 1'b1;

  // Width of the reported entry count.
  localparam int unsigned EntryCountW = 5;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } kvt_req_t;

  typedef struct packed {
    logic signed [31:0]      read_value;
    logic                    found;
    logic [EntryCountW-1:0]  entry_count;
    logic                    dropped_full;
  } kvt_rsp_t;

endpackage

[sv/key_value_table.sv]
// ----------------------------------------------------------------------------
// Key/value table
// Bounded associative table of signed 32-bit keys and values with unique keys.
// ----------------------------------------------------------------------------
// Usage: a request on in_req_i is taken when in_valid_i is high and in_stall_o
// is low. An add request (REQ_ADD) updates the value of a stored key or
// appends a new entry; a get request (REQ_GET) returns the stored value, or
// zero when the key is absent. Each request gives exactly one response on
// out_rsp_o with out_valid_o, held until a cycle in which out_stall_i is low.
// A single comparator walks the stored entries one per cycle from the key
// memory. Once the response is taken the block is idle and takes the next
// request at the following edge. The block handles one request at a time:
// in_stall_o stays high from acceptance until the response has been taken.
// While the receiver stalls, the response and all table state hold. Reset
// empties the table at once; no clearing pass is needed because only
// entries below the fill count are ever read. An add of a new key to a full
// table is dropped and flagged.
// ----------------------------------------------------------------------------
module key_value_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kvt_pkg::kvt_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kvt_pkg::kvt_rsp_t out_rsp_o
);

  import kvt_pkg::*;

  localparam int unsigned AddrW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CountW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CountW-1:0] DepthVal = CountW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_ACT  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] key_mem [TABLE_DEPTH];
  logic [31:0] val_mem [TABLE_DEPTH];

  kvt_req_t          req_q;
  logic [CountW-1:0] fill_q, fill_d;
  logic [CountW-1:0] scan_idx_q, scan_idx_d;
  logic [CountW-1:0] cmp_idx_q;
  logic              cmp_vld_q, cmp_vld_d;
  logic [31:0]       key_rd_q;
  logic [31:0]       val_rd_q;
  logic [AddrW-1:0]  slot_q, slot_d;
  logic              hit_q, hit_d;
  logic              drop_q, drop_d;

  logic in_acc;
  logic key_match;
  logic scan_more;
  logic is_get;
  logic has_room;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  // The one comparator, shared by every step of the scan.
  assign key_match = cmp_vld_q && (key_rd_q == 32'(req_q.key));
  assign scan_more = (scan_idx_q < fill_q);
  assign is_get    = (req_q.req_type == REQ_GET);
  assign has_room  = (fill_q < DepthVal);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    scan_idx_d = scan_idx_q;
    cmp_vld_d  = 1'b0;
    slot_d     = slot_q;
    hit_d      = hit_q;
    drop_d     = drop_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          scan_idx_d = '0;
          hit_d      = 1'b0;
          drop_d     = 1'b0;
          state_d    = (fill_q == '0) ? ST_ACT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmp_vld_d  = scan_more;
        scan_idx_d = scan_idx_q + 1'b1;
        if (key_match) begin
          hit_d   = 1'b1;
          slot_d  = cmp_idx_q[AddrW-1:0];
          state_d = ST_ACT;
        end else if (cmp_vld_q && !scan_more) begin
          state_d = ST_ACT;
        end
      end
      ST_ACT: begin
        if (!is_get && !hit_q) begin
          if (has_room) begin
            fill_d = fill_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      drop_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      scan_idx_q <= scan_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      hit_q      <= hit_d;
      drop_q     <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
    slot_q    <= slot_d;
    cmp_idx_q <= scan_idx_q;
  end

  // Key memory: one read per scan step, written on an insert.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && scan_more) begin
      key_rd_q <= key_mem[scan_idx_q[AddrW-1:0]];
    end
    if ((state_q == ST_ACT) && !is_get && !hit_q && has_room) begin
      key_mem[fill_q[AddrW-1:0]] <= 32'(req_q.key);
    end
  end

  // Value memory: read on a get hit, written on an update or an insert.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACT) begin
      if (is_get) begin
        if (hit_q) begin
          val_rd_q <= val_mem[slot_q];
        end
      end else if (hit_q) begin
        val_mem[slot_q] <= 32'(req_q.value);
      end else if (has_room) begin
        val_mem[fill_q[AddrW-1:0]] <= 32'(req_q.value);
      end
    end
  end

  always_comb begin
    out_rsp_o.read_value   = (is_get && hit_q) ? $signed(val_rd_q) : 32'sd0;
    out_rsp_o.found        = hit_q;
    out_rsp_o.entry_count  = EntryCountW'(fill_q);
    out_rsp_o.dropped_full = drop_q;
  end

  // The table never holds more entries than it has room for.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthVal)
    else $error("fill count exceeds table depth");

  // The fill count only grows, and by one at a time.
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1))
    else $error("fill count changed by other than one");

  // A dropped request never reports a hit and is never a get.
  a_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.dropped_full) |->
      (!out_rsp_o.found && (req_q.req_type == REQ_ADD)))
    else $error("dropped flag on a hit or a get");

  // No new request is taken while a response is pending.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted while a response is pending");

endmodule

[sim/kvt_lookup_checker.sv]
// ----------------------------------------------------------------------------
// Key/value table lookup checker
// Watches both channels of the key/value table, keeps its own copy of the
// table to predict each response, and compares every response taken from the
// block, field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
module kvt_lookup_checker
  import kvt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  kvt_req_t in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  kvt_rsp_t out_rsp_i,
  output int       fail_count_o,
  output int       pending_o
);

  localparam int MaxReports = 100;

  logic signed [31:0] stored_keys [TABLE_DEPTH];
  logic signed [31:0] stored_vals [TABLE_DEPTH];
  int unsigned        stored_count;

  kvt_rsp_t predicted_rsps [$];
  kvt_rsp_t want;
  int       fail_count = 0;
  int       pending    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  // Applies one request to the shadow table and returns the response it gives.
  function automatic kvt_rsp_t apply_request(input kvt_req_t req);
    kvt_rsp_t    rsp;
    int unsigned slot;
    int unsigned i;
    logic        hit;
    rsp  = '0;
    hit  = 1'b0;
    slot = 0;
    for (i = 0; i < stored_count; i++) begin
      if (!hit && stored_keys[i] === req.key) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    rsp.found = hit;
    if (req.req_type == REQ_GET) begin
      if (hit) rsp.read_value = stored_vals[slot];
    end else if (hit) begin
      stored_vals[slot] = req.value;
    end else if (stored_count < TABLE_DEPTH) begin
      stored_keys[stored_count] = req.key;
      stored_vals[stored_count] = req.value;
      stored_count++;
    end else begin
      rsp.dropped_full = 1'b1;
    end
    rsp.entry_count = EntryCountW'(stored_count);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_count = 0;
      predicted_rsps.delete();
      pending = 0;
    end else begin
      // The response leaving now always belongs to an earlier request, so it
      // is checked before a request taken at the same edge is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (predicted_rsps.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("%0t: response with none outstanding: value %0d found %0b count %0d dropped %0b",
                     $time, out_rsp_i.read_value, out_rsp_i.found,
                     out_rsp_i.entry_count, out_rsp_i.dropped_full);
          end
        end else begin
          want = predicted_rsps.pop_front();
          if (out_rsp_i.read_value !== want.read_value || out_rsp_i.found !== want.found ||
              out_rsp_i.entry_count !== want.entry_count ||
              out_rsp_i.dropped_full !== want.dropped_full) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
              $display("%0t: expected value %0d found %0b count %0d dropped %0b, got value %0d found %0b count %0d dropped %0b",
                       $time, want.read_value, want.found, want.entry_count,
                       want.dropped_full, out_rsp_i.read_value, out_rsp_i.found,
                       out_rsp_i.entry_count, out_rsp_i.dropped_full);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted_rsps.push_back(apply_request(in_req_i));
      end
      pending = predicted_rsps.size();
    end
  end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Key/value table testbench
// Drives directed and random add and get requests into the key/value table in
// bursts, stalls the response side on a changing pattern, and reports the
// verdict from the lookup checker that runs beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import kvt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int          RandomItems = 1800;
  localparam int          CycleLimit  = 1000000;

  localparam int StallNone   = 0;
  localparam int StallLight  = 1;
  localparam int StallHeavy  = 2;
  localparam int StallToggle = 3;

  localparam logic signed [31:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [31:0] KeyMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] KeyOverflow = 32'sh1234_5678;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  kvt_req_t in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  kvt_rsp_t out_rsp;
  int       fail_count;
  int       pending;

  int cycle_count = 0;
  int stall_mode  = StallNone;
  int stall_run   = 0;

  // Keys known to be in the table once the directed part has filled it.
  logic signed [31:0] known_keys [TABLE_DEPTH];

  always #5 clk = ~clk;

  key_value_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  kvt_lookup_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The response side switches between stall patterns every so often.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(StallNone, StallToggle);
      stall_run  <= $urandom_range(10, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= ~out_stall;
    endcase
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following request goes out without a gap.
  task automatic issue_request(input logic kind, input logic signed [31:0] key,
                               input logic signed [31:0] value);
    kvt_req_t req;
    req.req_type = kind;
    req.key      = key;
    req.value    = value;
    in_req   <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_responses();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int                 burst_left;
    int                 pick;
    logic signed [31:0] key;
    logic               kind;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Lookup on an empty table, then the extreme keys and values.
    issue_request(REQ_GET, KeyMin, 32'sh7fff_ffff);
    issue_request(REQ_ADD, KeyMin, 32'sh7fff_ffff);
    issue_request(REQ_ADD, KeyMax, 32'sh8000_0000);
    issue_request(REQ_ADD, 32'sd0, -32'sd1);
    issue_request(REQ_ADD, -32'sd1, 32'sd0);
    known_keys[0] = KeyMin;
    known_keys[1] = KeyMax;
    known_keys[2] = 32'sd0;
    known_keys[3] = -32'sd1;
    for (int i = 0; i < 4; i++) issue_request(REQ_GET, known_keys[i], 32'sd0);
    // Update of a present key, then a get whose value field must be ignored.
    issue_request(REQ_ADD, KeyMin, 32'sh5a5a_5a5a);
    issue_request(REQ_GET, KeyMin, -32'sd1);
    // A key one bit away from a stored one must miss.
    issue_request(REQ_GET, 32'sd1, -32'sd1);
    for (int i = 4; i < TABLE_DEPTH; i++) begin
      known_keys[i] = 32'sh5555_0000 + i;
      issue_request(REQ_ADD, known_keys[i], $urandom);
    end
    // The table is full now: a new key is dropped and stays absent.
    issue_request(REQ_ADD, KeyOverflow, 32'sh0bad_cafe);
    issue_request(REQ_GET, KeyOverflow, 32'sd0);
    issue_request(REQ_GET, known_keys[TABLE_DEPTH-1], 32'sd0);
    wait_for_responses();

    burst_left = $urandom_range(1, 24);
    for (int n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        key = known_keys[$urandom_range(0, TABLE_DEPTH - 1)];
      end else if (pick < 70) begin
        key = known_keys[$urandom_range(0, TABLE_DEPTH - 1)] ^ (32'sd1 << $urandom_range(0, 31));
      end else begin
        key = $urandom;
      end
      kind = 1'($urandom_range(0, 1));
      issue_request(kind, key, $urandom);
      if (n == RandomItems / 2) begin
        wait_for_responses();
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk);
          burst_left = $urandom_range(1, 24);
        end
      end
    end

    wait_for_responses();
    repeat (TABLE_DEPTH + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
